>>> design/assert_macros.svh
// Assertion helpers shared by the design files.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies the consequent at the next
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/mm4_pkg.sv
package mm4_pkg;

  // Fixed field widths of the channels
  localparam int IN_W    = 16;
  localparam int VALUE_W = 34;
  localparam int IDX_W   = 4;

  // Defaults for the top-level parameters
  localparam int MATRIX_DIM_DEF = 4;
  localparam int ELEM_WIDTH_DEF = 16;

  // Job queue between front and back: one slot per matrix bank
  localparam int QUEUE_DEPTH = 2;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [IN_W-1:0] a_value;
    logic signed [IN_W-1:0] b_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] element_value;
    logic [IDX_W-1:0]          element_index;
    logic                      last_element;
  } out_beat_t;

  // One loaded matrix pair waiting to be multiplied
  typedef struct packed {
    logic bank;
  } job_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic [QCNT_W-1:0] count;
    job_t              head;
  } q_stat_t;

endpackage

>>> design/mm4_ram.sv
module mm4_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/mm4_front.sv
module mm4_front import mm4_pkg::*; #(
  parameter int MATRIX_DIM = MATRIX_DIM_DEF,
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        start,
  output logic                                        busy,
  input  in_beat_t                                    in_beat,
  input  q_stat_t                                     q_stat,
  input  logic                                        back_active,
  output logic                                        push,
  output job_t                                        push_job,
  output logic                                        wr_en,
  output logic [$clog2(MATRIX_DIM*MATRIX_DIM):0]      wr_addr,
  output logic [ELEM_WIDTH-1:0]                       wr_a,
  output logic [ELEM_WIDTH-1:0]                       wr_b
);

  localparam int CELLS  = MATRIX_DIM * MATRIX_DIM;
  localparam int CELL_W = $clog2(CELLS);

  logic [CELL_W-1:0] count_r, count_nxt;
  logic              bank_r, bank_nxt;
  logic              accept;
  logic              batch_done;

  // Both banks taken: one queued or in work, plus one more
  assign busy = (q_stat.count == QCNT_W'(QUEUE_DEPTH)) ||
                ((q_stat.count == QCNT_W'(1)) && back_active);

  assign accept     = start && !busy;
  assign batch_done = (count_r == CELL_W'(CELLS - 1));

  // Element write into the current bank
  assign wr_en   = accept;
  assign wr_addr = {bank_r, count_r};
  assign wr_a    = ELEM_WIDTH'($unsigned(in_beat.a_value));
  assign wr_b    = ELEM_WIDTH'($unsigned(in_beat.b_value));

  // Hand a full bank to the back end
  assign push          = accept && batch_done;
  assign push_job.bank = bank_r;

  always_comb begin
    count_nxt = count_r;
    bank_nxt  = bank_r;
    if (accept) begin
      if (batch_done) begin
        count_nxt = '0;
        bank_nxt  = !bank_r;
      end else begin
        count_nxt = count_r + CELL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      bank_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      bank_r  <= bank_nxt;
    end
  end

endmodule

>>> design/mm4_queue.sv
module mm4_queue import mm4_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output q_stat_t q_stat
);

  `include "assert_macros.svh"

  job_t              ent_r [QUEUE_DEPTH];
  logic [QCNT_W-1:0] count_r;

  assign q_stat.count = count_r;
  assign q_stat.head  = ent_r[0];

  // Occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (push && !pop) begin
      count_r <= count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_r <= count_r - QCNT_W'(1);
    end
  end

  // Two-entry shift queue, head at entry 0
  always_ff @(posedge clk) begin
    unique case ({push, pop})
      2'b10: begin
        if (count_r == '0) begin
          ent_r[0] <= push_job;
        end else begin
          ent_r[1] <= push_job;
        end
      end
      2'b01: begin
        ent_r[0] <= ent_r[1];
      end
      2'b11: begin
        if (count_r == QCNT_W'(1)) begin
          ent_r[0] <= push_job;
        end else begin
          ent_r[0] <= ent_r[1];
          ent_r[1] <= push_job;
        end
      end
      default: begin
      end
    endcase
  end

  `ASSERT_ALWAYS(a_no_overflow, !(push && count_r == QCNT_W'(QUEUE_DEPTH)), "job queue overflow")
  `ASSERT_ALWAYS(a_no_underflow, !(pop && count_r == '0), "job queue underflow")

endmodule

>>> design/mm4_back.sv
module mm4_back import mm4_pkg::*; #(
  parameter int MATRIX_DIM = MATRIX_DIM_DEF,
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  q_stat_t                                q_stat,
  output logic                                   pop,
  output logic                                   active,
  output logic [$clog2(MATRIX_DIM*MATRIX_DIM):0] a_raddr,
  output logic [$clog2(MATRIX_DIM*MATRIX_DIM):0] b_raddr,
  input  logic [ELEM_WIDTH-1:0]                  a_rdata,
  input  logic [ELEM_WIDTH-1:0]                  b_rdata,
  output logic                                   out_valid,
  output out_beat_t                              out_beat
);

  `include "assert_macros.svh"

  localparam int CELLS  = MATRIX_DIM * MATRIX_DIM;
  localparam int CELL_W = $clog2(CELLS);
  localparam int DIM_W  = $clog2(MATRIX_DIM);
  localparam int PROD_W = 2 * ELEM_WIDTH;
  localparam logic [DIM_W-1:0] DIM_LAST = DIM_W'(MATRIX_DIM - 1);

  // Issue sequencer
  logic              active_r;
  logic              bank_r;
  logic [DIM_W-1:0]  row_r, col_r, k_r;
  logic              issue_last;

  // Read-data stage and product stage
  logic              s1_valid_r, s1_first_r, s1_last_r;
  logic [CELL_W-1:0] s1_cell_r;
  logic              s2_valid_r, s2_first_r, s2_last_r;
  logic [CELL_W-1:0] s2_cell_r;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;

  // Accumulator and result register
  logic signed [VALUE_W-1:0] acc_r, acc_nxt;
  logic                      out_valid_r;
  out_beat_t                 out_beat_r;

  assign issue_last = active_r && (row_r == DIM_LAST) && (col_r == DIM_LAST) &&
                      (k_r == DIM_LAST);
  assign pop    = (q_stat.count != '0) && (!active_r || issue_last);
  assign active = active_r;

  // A[row][k] and B[k][col] of the bank in work
  assign a_raddr = {bank_r, CELL_W'(row_r * MATRIX_DIM + k_r)};
  assign b_raddr = {bank_r, CELL_W'(k_r * MATRIX_DIM + col_r)};

  // k innermost, then column, then row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      row_r    <= '0;
      col_r    <= '0;
      k_r      <= '0;
    end else if (pop) begin
      active_r <= 1'b1;
      row_r    <= '0;
      col_r    <= '0;
      k_r      <= '0;
    end else if (issue_last) begin
      active_r <= 1'b0;
    end else if (active_r) begin
      if (k_r == DIM_LAST) begin
        k_r <= '0;
        if (col_r == DIM_LAST) begin
          col_r <= '0;
          row_r <= row_r + DIM_W'(1);
        end else begin
          col_r <= col_r + DIM_W'(1);
        end
      end else begin
        k_r <= k_r + DIM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      bank_r <= q_stat.head.bank;
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= active_r;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r && s2_last_r;
    end
  end

  // Tags follow the operands down the pipe
  always_ff @(posedge clk) begin
    s1_first_r <= (k_r == '0);
    s1_last_r  <= (k_r == DIM_LAST);
    s1_cell_r  <= CELL_W'(row_r * MATRIX_DIM + col_r);
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_cell_r  <= s1_cell_r;
    prod_r     <= prod_nxt;
  end

  // Single multiplier
  assign prod_nxt = $signed(a_rdata) * $signed(b_rdata);

  // Accumulate, wrapping at the result width
  assign acc_nxt = (s2_first_r ? '0 : acc_r) + VALUE_W'(prod_r);

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      acc_r <= acc_nxt;
    end
    if (s2_valid_r && s2_last_r) begin
      out_beat_r.element_value <= acc_nxt;
      out_beat_r.element_index <= IDX_W'(s2_cell_r);
      out_beat_r.last_element  <= (s2_cell_r == CELL_W'(CELLS - 1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  `ASSERT_NEXT(a_out_spacing, out_valid_r, !out_valid_r, "results closer than one per dot product")
  `ASSERT_NEXT(a_issue_runs, active_r && !issue_last, active_r, "issue stopped mid batch")

endmodule

>>> design/matrix_multiply_4x4.sv
// 4x4 matrix multiply, signed Q8.8 operands, exact Q18.16 results.
// Input channel: an element pair (A and B at the same row-major position)
// is taken on a clock edge with start high and busy low. Sixteen beats load
// one matrix pair; beats arrive in row-major order.
// Result channel: after the sixteenth beat, sixteen product elements come
// out in row-major order, each on out_beat for one cycle with out_valid
// high; the final one has last_element set. The receiver cannot stall, so
// every result must be taken in the cycle it is shown.
// Results: the back end reads A[row][k] and B[k][col] from operand RAM,
// multiplies them and accumulates, one element per dot product of MATRIX_DIM
// products (4 by default). A single multiply-accumulate unit does all the
// work, so it limits the sustained input rate; busy holds the sender off.
// Two banks of operand RAM let the next pair load while the previous one is
// multiplied; busy rises once both banks are taken.
// Reset (rst_n low, synchronous) clears the load count, the job queue and
// the pipeline; operand RAM contents are not cleared.
module matrix_multiply_4x4 import mm4_pkg::*; #(
  parameter int MATRIX_DIM = MATRIX_DIM_DEF,
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  output out_beat_t out_beat
);

  localparam int CELL_W = $clog2(MATRIX_DIM * MATRIX_DIM);
  localparam int ADDR_W = CELL_W + 1;
  localparam int DEPTH  = 2 ** ADDR_W;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ELEM_WIDTH-1:0] wr_a, wr_b;
  logic [ADDR_W-1:0] a_raddr, b_raddr;
  logic [ELEM_WIDTH-1:0] a_rdata, b_rdata;
  logic              push, pop, back_active;
  job_t              push_job;
  q_stat_t           q_stat;

  mm4_front #(
    .MATRIX_DIM (MATRIX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_beat     (in_beat),
    .q_stat      (q_stat),
    .back_active (back_active),
    .push        (push),
    .push_job    (push_job),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_a        (wr_a),
    .wr_b        (wr_b)
  );

  mm4_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_stat   (q_stat)
  );

  // Operand stores, two banks each
  mm4_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_a),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mm4_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_b),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  mm4_back #(
    .MATRIX_DIM (MATRIX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop       (pop),
    .active    (back_active),
    .a_raddr   (a_raddr),
    .b_raddr   (b_raddr),
    .a_rdata   (a_rdata),
    .b_rdata   (b_rdata),
    .out_valid (out_valid),
    .out_beat  (out_beat)
  );

endmodule

>>> test/matrix_multiply_4x4_tb.sv
module matrix_multiply_4x4_tb;
  import mm4_pkg::*;

  localparam int DIM         = MATRIX_DIM_DEF;
  localparam int CELLS       = DIM * DIM;
  localparam int CYCLE_LIMIT = 200_000;
  // extra wait after the last predicted element, to catch stray results
  localparam int SETTLE      = 2 * (7 + DIM * CELLS);

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  out_beat_t out_beat;

  matrix_multiply_4x4 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_beat  (out_beat)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Operand copies and load position of the model
  logic signed [IN_W-1:0] a_cells [CELLS];
  logic signed [IN_W-1:0] b_cells [CELLS];
  int                     load_pos = 0;
  out_beat_t              pending_elements [$];
  bit                     failed = 1'b0;
  int                     cycle_count = 0;

  // Store one element pair; the last pair of a batch yields the whole product
  function automatic void load_element(in_beat_t b);
    longint    acc;
    out_beat_t e;
    a_cells[load_pos] = b.a_value;
    b_cells[load_pos] = b.b_value;
    if (load_pos != CELLS - 1) begin
      load_pos++;
      return;
    end
    load_pos = 0;
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        acc = 0;
        for (int k = 0; k < DIM; k++)
          acc += longint'(a_cells[r*DIM+k]) * longint'(b_cells[k*DIM+c]);
        e.element_value = acc[VALUE_W-1:0];
        e.element_index = IDX_W'(r * DIM + c);
        e.last_element  = (r * DIM + c == CELLS - 1);
        pending_elements.push_back(e);
      end
    end
  endfunction

  // Operand mix: full range, small, extremes, zero
  function automatic logic [IN_W-1:0] pick_operand();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return '0;
      3:       return IN_W'($signed($urandom_range(0, 1023)) - 512);
      default: return IN_W'($urandom);
    endcase
  endfunction

  // Send one beat after an idle gap; start stays high across back-to-back beats
  task automatic send_beat(in_beat_t b, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_beat <= b;
    do @(posedge clk); while (busy);
    load_element(b);
  endtask

  // Hold the sender off until every predicted element has come out
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_elements.size() != 0);
  endtask

  task automatic send_random_batch(int max_gap);
    in_beat_t b;
    for (int i = 0; i < CELLS; i++) begin
      b.a_value = pick_operand();
      b.b_value = pick_operand();
      send_beat(b, $urandom_range(0, max_gap));
    end
  endtask

  // A all most-negative; B columns 0,1 most-negative, 2,3 most-positive:
  // products hit both ends of the result range
  task automatic test_extreme_operands();
    in_beat_t b;
    for (int i = 0; i < CELLS; i++) begin
      b.a_value = 16'h8000;
      b.b_value = (i % DIM < DIM / 2) ? 16'h8000 : 16'h7fff;
      send_beat(b, 0);
    end
    drain_results();
  endtask

  // No sender gaps: the block must push back with busy
  task automatic test_back_to_back(int batches);
    repeat (batches) send_random_batch(0);
    drain_results();
  endtask

  // Random gaps on every beat
  task automatic test_random_idling(int batches);
    repeat (batches) send_random_batch(19);
  endtask

  // Stretches of full rate and of gaps, with occasional full drains
  task automatic test_bursty_idling(int batches);
    repeat (batches) begin
      send_random_batch($urandom_range(0, 1) ? 19 : 0);
      if ($urandom_range(0, 2) == 0) drain_results();
    end
  endtask

  // Compare every result beat with the oldest prediction
  always @(posedge clk) begin
    out_beat_t exp_e;
    if (rst_n && out_valid) begin
      if (pending_elements.size() == 0) begin
        $display("%0t: unexpected element, got %h", $realtime, out_beat);
        failed = 1'b1;
      end else begin
        exp_e = pending_elements.pop_front();
        if (out_beat.element_value !== exp_e.element_value) begin
          $display("%0t: element_value expected %h got %h", $realtime,
                   exp_e.element_value, out_beat.element_value);
          failed = 1'b1;
        end
        if (out_beat.element_index !== exp_e.element_index) begin
          $display("%0t: element_index expected %h got %h", $realtime,
                   exp_e.element_index, out_beat.element_index);
          failed = 1'b1;
        end
        if (out_beat.last_element !== exp_e.last_element) begin
          $display("%0t: last_element expected %b got %b", $realtime,
                   exp_e.last_element, out_beat.last_element);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extreme_operands();
    test_back_to_back(8);
    test_random_idling(12);
    test_bursty_idling(9);

    start <= 1'b0;
    while (pending_elements.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
